// File: rtl/cbf_pkg.sv
// cbf_pkg: shared types and constants for the circular byte FIFO.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cbf_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BURST_DEF = 64;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 7;
	localparam int SIZE_W  = 11;
	localparam int STAT_W  = 10;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_CLR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_READ,
		S_DATA,
		S_WAIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // request taken, perform enqueue / clear / burst setup
		logic read;       // read byte at read index, advance it
		logic load_resp;  // load single result (no data)
		logic load_data;  // load dequeued byte as result
	} cbf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic deq_go;     // current request is a dequeue with at least one byte
		logic more;       // burst bytes still to read
		logic out_taken;  // result register handed over this cycle
	} cbf_stat_t;

endpackage

// File: rtl/cbf_in_if.sv
// cbf_in_if: request channel of the circular byte FIFO (valid/ready + payload).
// Depends on cbf_pkg for field widths.
interface cbf_in_if;
	import cbf_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [DATA_W-1:0]  data_in;
	logic [COUNT_W-1:0] burst_count;

	modport source (output valid, output operation, output data_in, output burst_count,
		input ready);
	modport sink (input valid, input operation, input data_in, input burst_count,
		output ready);

endinterface

// File: rtl/cbf_out_if.sv
// cbf_out_if: result channel of the circular byte FIFO (valid/ready + payload).
// Depends on cbf_pkg for field widths.
interface cbf_out_if;
	import cbf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_out;
	logic              ok;
	logic              last;
	logic [STAT_W-1:0] used_count;
	logic [STAT_W-1:0] free_count;
	logic              is_empty;
	logic              is_full;

	modport source (output valid, output data_out, output ok, output last,
		output used_count, output free_count, output is_empty, output is_full,
		input ready);
	modport sink (input valid, input data_out, input ok, input last,
		input used_count, input free_count, input is_empty, input is_full,
		output ready);

endinterface

// File: rtl/cbf_ctrl.sv
// cbf_ctrl: sequencing state machine of the circular byte FIFO.
// Depends on cbf_pkg (state_t, cbf_cmd_t, cbf_stat_t).
module cbf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cbf_pkg::cbf_stat_t stat,
	output cbf_pkg::cbf_cmd_t  cmd
);
	import cbf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = stat.deq_go ? S_READ : S_RESP;
				end
			end
			S_RESP: state_nxt = S_WAIT;
			S_READ: state_nxt = S_DATA;
			S_DATA: state_nxt = S_WAIT;
			S_WAIT: begin
				if (stat.out_taken) begin
					state_nxt = stat.more ? S_READ : S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == S_IDLE);
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.read      = (state_q == S_READ);
		cmd.load_resp = (state_q == S_RESP);
		cmd.load_data = (state_q == S_DATA);
	end

endmodule

// File: rtl/cbf_dp.sv
// cbf_dp: datapath of the circular byte FIFO: byte store, indices, size
// register, occupancy logic and result register. Depends on cbf_pkg, cbf_out_if.
module cbf_dp #(
	parameter int DEPTH     = cbf_pkg::DEPTH_DEF,
	parameter int MAX_BURST = cbf_pkg::MAX_BURST_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        size_we,
	input  logic [cbf_pkg::SIZE_W-1:0]  size_wdata,
	input  logic [cbf_pkg::OP_W-1:0]    operation,
	input  logic [cbf_pkg::DATA_W-1:0]  data_in,
	input  logic [cbf_pkg::COUNT_W-1:0] burst_count,
	input  cbf_pkg::cbf_cmd_t           cmd,
	output cbf_pkg::cbf_stat_t          stat,
	cbf_out_if.source                   result
);
	import cbf_pkg::*;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int SZ_W    = $clog2(DEPTH + 1);
	localparam int BURST_W = $clog2(MAX_BURST + 1);

	logic [DATA_W-1:0]  mem [DEPTH];
	logic [DATA_W-1:0]  rdata_q;

	logic [IDX_W-1:0]   wr_q;
	logic [IDX_W-1:0]   rd_q;
	logic [SZ_W-1:0]    size_q;
	logic [BURST_W-1:0] remain_q;
	logic               ok_q;
	logic               out_valid_q;

	logic [IDX_W-1:0]   wr_nxt;
	logic [IDX_W-1:0]   rd_nxt;
	logic [SZ_W-1:0]    used_w;
	logic [SZ_W-1:0]    free_w;
	logic               empty_w;
	logic               full_w;
	logic [SZ_W-1:0]    size_clamp;
	logic [BURST_W-1:0] cnt_clamp;
	logic [BURST_W-1:0] n_w;
	logic               is_enq;
	logic               is_deq;
	logic               is_clr;
	logic               enq_ok;

	// occupancy from the two indices
	always_comb begin
		wr_nxt = (SZ_W'(wr_q) + SZ_W'(1) >= size_q) ? '0 : wr_q + IDX_W'(1);
		rd_nxt = (SZ_W'(rd_q) + SZ_W'(1) >= size_q) ? '0 : rd_q + IDX_W'(1);
		if (wr_q >= rd_q) begin
			used_w = SZ_W'(wr_q) - SZ_W'(rd_q);
		end else begin
			used_w = size_q - SZ_W'(rd_q) + SZ_W'(wr_q);
		end
		free_w  = size_q - SZ_W'(1) - used_w;
		empty_w = (wr_q == rd_q);
		full_w  = (wr_nxt == rd_q);
	end

	// request decode and burst length
	always_comb begin
		is_enq = (operation == OP_ENQ);
		is_deq = (operation == OP_DEQ);
		is_clr = (operation == OP_CLR);
		enq_ok = is_enq && !full_w;
		if (32'(burst_count) > 32'(MAX_BURST)) begin
			cnt_clamp = BURST_W'(MAX_BURST);
		end else begin
			cnt_clamp = BURST_W'(burst_count);
		end
		if (32'(used_w) < 32'(cnt_clamp)) begin
			n_w = BURST_W'(used_w);
		end else begin
			n_w = cnt_clamp;
		end
	end

	// size write is clamped to 2..DEPTH
	always_comb begin
		priority if (size_wdata < SIZE_W'(2)) begin
			size_clamp = SZ_W'(2);
		end else if (32'(size_wdata) > 32'(DEPTH)) begin
			size_clamp = SZ_W'(DEPTH);
		end else begin
			size_clamp = SZ_W'(size_wdata);
		end
	end

	always_comb begin
		stat.deq_go    = is_deq && (n_w != '0);
		stat.more      = (remain_q != '0);
		stat.out_taken = out_valid_q && result.ready;
	end

	// byte store
	always_ff @(posedge clk) begin
		if (cmd.accept && enq_ok) begin
			mem[wr_q] <= data_in;
		end
		if (cmd.read) begin
			rdata_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			size_q      <= SZ_W'(DEPTH);
			remain_q    <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (size_we) begin
				size_q <= size_clamp;
				wr_q   <= '0;
				rd_q   <= '0;
			end else if (cmd.accept) begin
				ok_q     <= enq_ok || is_clr;
				remain_q <= is_deq ? n_w : '0;
				if (is_clr) begin
					wr_q <= '0;
					rd_q <= '0;
				end else if (enq_ok) begin
					wr_q <= wr_nxt;
				end
			end else if (cmd.read) begin
				rd_q     <= rd_nxt;
				remain_q <= remain_q - BURST_W'(1);
			end
			if (cmd.load_resp || cmd.load_data) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_resp || cmd.load_data) begin
			result.data_out   <= cmd.load_data ? rdata_q : '0;
			result.ok         <= cmd.load_data ? 1'b1 : ok_q;
			result.last       <= cmd.load_data ? (remain_q == '0) : 1'b1;
			result.used_count <= STAT_W'(used_w);
			result.free_count <= STAT_W'(free_w);
			result.is_empty   <= empty_w;
			result.is_full    <= full_w;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// File: rtl/circular_byte_fifo.sv
// circular_byte_fifo: top level of the byte ring buffer with a run-time size.
// Depends on cbf_pkg, cbf_in_if, cbf_out_if, cbf_ctrl and cbf_dp.
//
// Usage notes
// - req: valid/ready request channel carrying operation (enqueue, dequeue
//   burst, clear), data_in and burst_count. A request is taken when valid
//   and ready are both high; ready is high only while no request is in work.
// - result: valid/ready channel; each result carries the dequeued byte (or
//   zero), ok, last and the occupancy after it (used, free, empty, full).
// - size_we/size_wdata: writes the active ring size (clamped to 2..DEPTH)
//   and empties the queue. Capacity is size minus one.
// - Enqueue, clear and failed dequeue give one result, loaded in the
//   response state after the request is taken. Burst bytes are read,
//   loaded and handed over one after another through the registered read
//   of the single-port byte store; each waits for the last to be taken.
// - Reset (arst_n low) empties the queue and sets the size to DEPTH; store
//   contents are not cleared, so no clearing pass is needed.
// - When the receiver stalls the result register holds its value and the
//   sequencer waits; no new request is taken until the last result of the
//   current one has been handed over.
module circular_byte_fifo #(
	parameter int DEPTH     = cbf_pkg::DEPTH_DEF,
	parameter int MAX_BURST = cbf_pkg::MAX_BURST_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       size_we,
	input  logic [cbf_pkg::SIZE_W-1:0] size_wdata,
	cbf_in_if.sink                     req,
	cbf_out_if.source                  result
);
	import cbf_pkg::*;

	cbf_cmd_t  cmd;
	cbf_stat_t stat;
	logic      ready_w;

	// sequencer: one request at a time, burst bytes one after another
	cbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (ready_w),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign req.ready = ready_w;

	// store, indices, size register and result register
	cbf_dp #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.size_we     (size_we),
		.size_wdata  (size_wdata),
		.operation   (req.operation),
		.data_in     (req.data_in),
		.burst_count (req.burst_count),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result)
	);

endmodule

// File: tb/circular_byte_fifo_tb.sv
// circular_byte_fifo_tb: self-checking bench for the circular byte FIFO.
// Needs cbf_pkg, cbf_in_if, cbf_out_if and the circular_byte_fifo RTL.
// A shadow ring predicts every result; random idling on both channels.
module circular_byte_fifo_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbf_pkg::*;

	// spare operation code, decoded by the block as "no operation"
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam int MIN_SIZE     = 2;
	localparam int IDLE_PCT     = 31;       // chance of a gap / stall per cycle
	localparam int DRAIN_CYCLES = 4;        // settle time before a size write
	localparam int CYCLE_LIMIT  = 1000000;  // whole-run watchdog
	localparam int HOLD_CYCLES  = 500;      // long receiver back-pressure
	localparam int HOLD_AT      = 260;      // results seen before the long hold
	localparam int HOLD_BACKLOG = 4;        // the hold starts only with more requests than this still queued
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
	} fifo_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic              ok;
		logic              last;
		logic [STAT_W-1:0] used_count;
		logic [STAT_W-1:0] free_count;
		logic              is_empty;
		logic              is_full;
	} fifo_reply_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              size_we;
	logic [SIZE_W-1:0] size_wdata;

	cbf_in_if  req_ch ();
	cbf_out_if res_ch ();

	circular_byte_fifo dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_we    (size_we),
		.size_wdata (size_wdata),
		.req        (req_ch),
		.result     (res_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the ring: byte store, indices and active size.
	// Updated when a request is taken, so results are known in advance.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] shadow_bytes [DEPTH_DEF];
	int                shadow_wr;
	int                shadow_rd;
	int                shadow_size;

	fifo_req_t   pending_reqs [$];   // requests still to be offered
	fifo_reply_t due_replies  [$];   // predicted results, oldest first

	int faults;
	int results_seen;
	int handed_out;
	int cycles;

	function automatic int ring_next(int idx);
		int nxt;
		nxt = idx + 1;
		if (nxt >= shadow_size)
			nxt = 0;
		return nxt;
	endfunction

	function automatic int ring_used();
		if (shadow_wr >= shadow_rd)
			return shadow_wr - shadow_rd;
		return shadow_size - shadow_rd + shadow_wr;
	endfunction

	// occupancy fields always reflect the ring after this result
	function automatic fifo_reply_t ring_reply(logic [DATA_W-1:0] data, logic ok, logic last);
		fifo_reply_t r;
		int          used;
		used         = ring_used();
		r.data_out   = data;
		r.ok         = ok;
		r.last       = last;
		r.used_count = STAT_W'(used);
		r.free_count = STAT_W'(shadow_size - 1 - used);
		r.is_empty   = (shadow_wr == shadow_rd);
		r.is_full    = (ring_next(shadow_wr) == shadow_rd);
		return r;
	endfunction

	task automatic ring_take_request(fifo_req_t r);
		int nxt;
		int burst;
		int avail;
		if (r.op == OP_ENQ) begin
			nxt = ring_next(shadow_wr);
			if (nxt != shadow_rd) begin
				shadow_bytes[shadow_wr] = r.data;
				shadow_wr = nxt;
				due_replies.push_back(ring_reply('0, 1'b1, 1'b1));
			end else begin
				// full: refused, nothing stored
				due_replies.push_back(ring_reply('0, 1'b0, 1'b1));
			end
		end else if (r.op == OP_DEQ) begin
			burst = (r.count > MAX_BURST_DEF) ? MAX_BURST_DEF : int'(r.count);
			avail = ring_used();
			if (avail > burst)
				avail = burst;
			if (avail == 0) begin
				// empty queue or zero count: one failed result
				due_replies.push_back(ring_reply('0, 1'b0, 1'b1));
			end else begin
				for (int k = 0; k < avail; k++) begin
					logic [DATA_W-1:0] b;
					b = shadow_bytes[shadow_rd];
					shadow_rd = ring_next(shadow_rd);
					due_replies.push_back(ring_reply(b, 1'b1, k + 1 == avail));
				end
			end
		end else if (r.op == OP_CLR) begin
			shadow_wr = 0;
			shadow_rd = 0;
			due_replies.push_back(ring_reply('0, 1'b1, 1'b1));
		end else begin
			// spare code: refused, state untouched
			due_replies.push_back(ring_reply('0, 1'b0, 1'b1));
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver. Holds a request until taken; random gaps except
	// for a steady stretch of requests 200..299.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		fifo_req_t nxt_req;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				ring_take_request({req_ch.operation, req_ch.data_in, req_ch.burst_count});
			end
			if (req_ch.valid && !req_ch.ready) begin
				// keep offering the same request
			end else if (pending_reqs.size() != 0 &&
				((handed_out >= 200 && handed_out < 300) ||
				$urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt_req = pending_reqs.pop_front();
				handed_out <= handed_out + 1;
				req_ch.valid       <= 1'b1;
				req_ch.operation   <= nxt_req.op;
				req_ch.data_in     <= nxt_req.data;
				req_ch.burst_count <= nxt_req.count;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver. Random stalls, a stall-free stretch over results
	// 100..249, and one long hold-off so the block backs up and stops
	// taking requests while the driver keeps offering. The hold waits
	// for a backlog of queued requests so the driver has work to offer.
	// ------------------------------------------------------------------
	int hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT &&
			pending_reqs.size() > HOLD_BACKLOG) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (results_seen >= 100 && results_seen < 250) begin
			res_ch.ready <= 1'b1;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every handed-over result against the oldest
	// prediction. Only the first few faults are reported in full.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		fifo_reply_t got;
		fifo_reply_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.data_out, res_ch.ok, res_ch.last, res_ch.used_count,
				res_ch.free_count, res_ch.is_empty, res_ch.is_full};
			results_seen <= results_seen + 1;
			if (due_replies.size() == 0) begin
				if (faults < MAX_REPORTS)
					$display("%0t: unexpected result data=%h ok=%b last=%b used=%0d free=%0d e=%b f=%b",
						$realtime, got.data_out, got.ok, got.last, got.used_count,
						got.free_count, got.is_empty, got.is_full);
				faults++;
			end else begin
				want = due_replies.pop_front();
				if (got.data_out !== want.data_out || got.ok !== want.ok ||
					got.last !== want.last || got.used_count !== want.used_count ||
					got.free_count !== want.free_count || got.is_empty !== want.is_empty ||
					got.is_full !== want.is_full) begin
					if (faults < MAX_REPORTS) begin
						$display("%0t: result %0d mismatch", $realtime, results_seen);
						$display("  expected data=%h ok=%b last=%b used=%0d free=%0d e=%b f=%b",
							want.data_out, want.ok, want.last, want.used_count,
							want.free_count, want.is_empty, want.is_full);
						$display("  actual   data=%h ok=%b last=%b used=%0d free=%0d e=%b f=%b",
							got.data_out, got.ok, got.last, got.used_count,
							got.free_count, got.is_empty, got.is_full);
					end
					faults++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("circular_byte_fifo_tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] data,
		logic [COUNT_W-1:0] count);
		pending_reqs.push_back(fifo_req_t'{op: op, data: data, count: count});
	endtask

	// sampled on the falling edge, so every update of the rising edge has settled
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || due_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// size write only with the block idle; it also empties the ring
	task automatic write_queue_size(logic [SIZE_W-1:0] value);
		wait_drained();
		@(posedge clk);
		size_we    <= 1'b1;
		size_wdata <= value;
		if (value < MIN_SIZE)
			shadow_size = MIN_SIZE;
		else if (value > DEPTH_DEF)
			shadow_size = DEPTH_DEF;
		else
			shadow_size = int'(value);
		shadow_wr = 0;
		shadow_rd = 0;
		@(posedge clk);
		size_we <= 1'b0;
	endtask

	function automatic logic [COUNT_W-1:0] random_burst();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return COUNT_W'($urandom_range(MAX_BURST_DEF + 1, 127));
		if (pick == 2)
			return COUNT_W'(MAX_BURST_DEF);
		return COUNT_W'($urandom_range(1, 8));
	endfunction

	// mostly fill runs and bursts, with clears and spare codes mixed in
	task automatic random_phase(int n);
		int added;
		int pick;
		int run;
		int cap;
		added = 0;
		cap   = shadow_size - 1;
		while (added < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				run = $urandom_range(1, (cap + 2 > 12) ? 12 : cap + 2);
				repeat (run) begin
					queue_req(OP_ENQ, DATA_W'($urandom), COUNT_W'($urandom));
					added++;
				end
			end else if (pick < 80) begin
				queue_req(OP_DEQ, DATA_W'($urandom), random_burst());
				added++;
			end else if (pick < 90) begin
				queue_req(OP_CLR, DATA_W'($urandom), COUNT_W'($urandom));
				added++;
			end else begin
				queue_req(OP_SPARE, DATA_W'($urandom), COUNT_W'($urandom));
				added++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		size_we            = 1'b0;
		size_wdata         = '0;
		req_ch.valid       = 1'b0;
		req_ch.operation   = OP_ENQ;
		req_ch.data_in     = '0;
		req_ch.burst_count = '0;
		res_ch.ready       = 1'b0;
		faults             = 0;
		results_seen       = 0;
		handed_out         = 0;
		cycles             = 0;
		shadow_size        = DEPTH_DEF;
		shadow_wr          = 0;
		shadow_rd          = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks at the reset size
		queue_req(OP_DEQ, 8'h00, 7'd1);        // dequeue from empty
		queue_req(OP_DEQ, 8'h00, 7'd0);        // zero count on empty
		queue_req(OP_SPARE, 8'hFF, 7'h7F);     // spare code
		queue_req(OP_CLR, 8'h00, 7'd0);
		queue_req(OP_ENQ, 8'h00, 7'd0);
		queue_req(OP_ENQ, 8'hFF, 7'h7F);
		queue_req(OP_ENQ, 8'hA5, 7'd0);
		queue_req(OP_ENQ, 8'h5A, 7'd0);
		queue_req(OP_DEQ, 8'hFF, 7'd0);        // zero count, nothing removed
		queue_req(OP_SPARE, 8'h00, 7'd0);      // state must not move
		queue_req(OP_DEQ, 8'h00, 7'd2);
		queue_req(OP_DEQ, 8'h00, 7'h7F);       // count beyond what is held
		queue_req(OP_DEQ, 8'h00, 7'd1);
		queue_req(OP_ENQ, 8'h3C, 7'd0);
		queue_req(OP_ENQ, 8'hC3, 7'd0);
		queue_req(OP_CLR, 8'h00, 7'd0);        // clear with data held
		queue_req(OP_DEQ, 8'h00, 7'd64);
		queue_req(OP_ENQ, 8'h81, 7'd0);
		queue_req(OP_ENQ, 8'h7E, 7'd0);
		queue_req(OP_DEQ, 8'h00, 7'd64);
		queue_req(OP_CLR, 8'hFF, 7'h7F);
		queue_req(OP_ENQ, 8'h55, 7'h7F);

		// fill to full, clamp a long burst, then wrap the indices
		write_queue_size(11'd100);
		repeat (101) queue_req(OP_ENQ, DATA_W'($urandom), '0);
		queue_req(OP_DEQ, 8'h00, 7'h7F);
		queue_req(OP_DEQ, 8'h00, 7'd65);
		queue_req(OP_DEQ, 8'h00, 7'd1);
		repeat (30) queue_req(OP_ENQ, DATA_W'($urandom), '0);
		queue_req(OP_DEQ, 8'h00, 7'd40);

		// sizes below, at and above the legal range
		write_queue_size(11'd0);
		random_phase(35);
		write_queue_size(11'h7FF);
		random_phase(35);
		write_queue_size(11'd3);
		random_phase(35);
		write_queue_size(11'd1);
		random_phase(20);
		write_queue_size(11'd17);
		random_phase(45);
		write_queue_size(11'd1024);
		random_phase(30);
		write_queue_size(11'd1500);
		random_phase(25);
		write_queue_size(11'd9);
		random_phase(40);

		wait_drained();
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (faults == 0 && due_replies.size() == 0)
			$display("circular_byte_fifo_tb: PASS");
		else
			$display("circular_byte_fifo_tb: FAIL");
		$finish;
	end

endmodule
